// ===== hw/rtl/cbms_lim_pkg.sv =====
package cbms_lim_pkg;

    // per-signal tracking status
    typedef enum logic [1:0] {
        SIG_NEVER = 2'd0,
        SIG_FRESH = 2'd1,
        SIG_STALE = 2'd2
    } t_sig_status;

    // signal slots
    localparam logic [1:0] SIG_IDX_LIMITS = 2'd0;
    localparam logic [1:0] SIG_IDX_SOC    = 2'd1;
    localparam logic [1:0] SIG_IDX_ALARM  = 2'd2;
    localparam logic [1:0] SIG_IDX_ENABLE = 2'd3;
    localparam int         NUM_SIG        = 4;

    // item kinds on the input side
    localparam logic OP_FRAME    = 1'b0;
    localparam logic OP_SNAPSHOT = 1'b1;

    // frame identifiers
    localparam logic [10:0] ID_LIMITS = 11'h351;
    localparam logic [10:0] ID_SOC    = 11'h355;
    localparam logic [10:0] ID_ALARM  = 11'h35A;
    localparam logic [10:0] ID_ENABLE = 11'h35C;

    // minimum payload lengths
    localparam logic [3:0] MIN_LEN_LIMITS = 4'd6;
    localparam logic [3:0] MIN_LEN_SOC    = 4'd4;
    localparam logic [3:0] MIN_LEN_ALARM  = 4'd4;
    localparam logic [3:0] MIN_LEN_ENABLE = 4'd1;

    localparam logic [15:0] TIMEOUT_RESET = 16'd5000;
    localparam logic [15:0] SOC_MAX       = 16'd100;

    localparam int IN_DATA_W  = 128;
    localparam int OUT_DATA_W = 64;

endpackage

// ===== hw/rtl/cbms_lim_aging.sv =====
module cbms_lim_aging
    import cbms_lim_pkg::*;
(
    input  t_sig_status i_status,
    input  logic [31:0] i_last_ms,
    input  logic [31:0] i_now_ms,
    input  logic [15:0] i_timeout_ms,
    output t_sig_status o_status
);

    logic [31:0] w_age;
    logic        w_expired;

    // wraparound-safe age
    assign w_age     = i_now_ms - i_last_ms;
    assign w_expired = w_age >= {16'd0, i_timeout_ms};

    always_comb begin
        case (i_status)
            SIG_FRESH: begin
                o_status = w_expired ? SIG_STALE : SIG_FRESH;
            end
            SIG_STALE: begin
                o_status = SIG_STALE;
            end
            default: begin
                o_status = SIG_NEVER;
            end
        endcase
    end

endmodule

// ===== hw/rtl/can_bms_limit_receiver.sv =====
// a snapshot item passes the input register, then the result register, before it leaves
// throughput: one item per cycle, frames and snapshots mixed freely; a snapshot is held in
//   the input register only while the previous result waits at the output
// frames give no result; a snapshot gives exactly one
// reset (synchronous, active low) clears all signal status to never seen, both valid
//   flags, and sets the timeout register to 5000 ms
module can_bms_limit_receiver
    import cbms_lim_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    // configuration: signal timeout in ms
    input  logic                  i_cfg_wr_en,
    input  logic [15:0]           i_cfg_wr_data,

    // input items
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // [31:0] now_ms, [42:32] frame_id, [46:43] frame_len,
    // [110:47] frame_payload, [126:111] pack_voltage_cv, [127] zero
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // [0] operation
    input  logic                  i_s_axis_tuser,

    // result items
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // [0] ceiling_active, [30:1] ceiling_mw, [31] voltage_limit_valid,
    // [47:32] voltage_limit_dv, [48] alarm_on, [49] warning_on,
    // [50] charge_state_trusted, [58:51] charge_state_pct,
    // [59] disc_pending, [60] link_lost, [63:61] zero
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata
);

    // ---------------------------------------------------------------
    // configuration register
    // ---------------------------------------------------------------
    logic [15:0] r_timeout_ms;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_ms <= TIMEOUT_RESET;
        end else if (i_cfg_wr_en) begin
            r_timeout_ms <= i_cfg_wr_data;
        end
    end

    // ---------------------------------------------------------------
    // input register
    // ---------------------------------------------------------------
    logic               r_in_valid;
    logic               r_in_op;
    logic [31:0]        r_in_now;
    logic [10:0]        r_in_id;
    logic [3:0]         r_in_len;
    logic [63:0]        r_in_payload;
    logic signed [15:0] r_in_pcv;

    logic w_in_accept;
    logic w_out_free;
    logic w_proc_go;
    logic w_is_snap;

    // output slot is free when empty or when its item leaves this cycle
    assign w_out_free = !o_m_axis_tvalid || i_m_axis_tready;
    assign w_is_snap  = r_in_op == OP_SNAPSHOT;
    // frames retire without touching the output slot
    assign w_proc_go  = r_in_valid && (!w_is_snap || w_out_free);

    assign o_s_axis_tready = !r_in_valid || w_proc_go;
    assign w_in_accept     = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_proc_go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_in_op      <= i_s_axis_tuser;
            r_in_now     <= i_s_axis_tdata[31:0];
            r_in_id      <= i_s_axis_tdata[42:32];
            r_in_len     <= i_s_axis_tdata[46:43];
            r_in_payload <= i_s_axis_tdata[110:47];
            r_in_pcv     <= i_s_axis_tdata[126:111];
        end
    end

    // ---------------------------------------------------------------
    // signal state
    // ---------------------------------------------------------------
    t_sig_status        r_sig_status [NUM_SIG];
    logic [31:0]        r_sig_last_ms [NUM_SIG];
    logic signed [15:0] r_current_limit_da;
    logic signed [15:0] r_voltage_limit_dv;
    logic [15:0]        r_charge_state_raw;
    logic               r_alarm_flag;
    logic               r_warning_flag;
    logic               r_charge_enable_flag;

    t_sig_status        n_sig_status [NUM_SIG];
    logic [31:0]        n_sig_last_ms [NUM_SIG];
    logic signed [15:0] n_current_limit_da;
    logic signed [15:0] n_voltage_limit_dv;
    logic [15:0]        n_charge_state_raw;
    logic               n_alarm_flag;
    logic               n_warning_flag;
    logic               n_charge_enable_flag;

    // aged view of every signal at the snapshot's tick
    t_sig_status w_aged [NUM_SIG];

    for (genvar g = 0; g < NUM_SIG; g++) begin : g_age
        cbms_lim_aging u_aging (
            .i_status     (r_sig_status[g]),
            .i_last_ms    (r_sig_last_ms[g]),
            .i_now_ms     (r_in_now),
            .i_timeout_ms (r_timeout_ms),
            .o_status     (w_aged[g])
        );
    end

    // frame decode and state update
    always_comb begin
        n_sig_status         = r_sig_status;
        n_sig_last_ms        = r_sig_last_ms;
        n_current_limit_da   = r_current_limit_da;
        n_voltage_limit_dv   = r_voltage_limit_dv;
        n_charge_state_raw   = r_charge_state_raw;
        n_alarm_flag         = r_alarm_flag;
        n_warning_flag       = r_warning_flag;
        n_charge_enable_flag = r_charge_enable_flag;
        if (w_proc_go) begin
            if (w_is_snap) begin
                n_sig_status = w_aged;
            end else begin
                // short frames are dropped whole; unknown ids are ignored
                case (r_in_id)
                    ID_LIMITS: begin
                        if (r_in_len >= MIN_LEN_LIMITS) begin
                            n_voltage_limit_dv            = r_in_payload[15:0];
                            n_current_limit_da            = r_in_payload[31:16];
                            n_sig_status[SIG_IDX_LIMITS]  = SIG_FRESH;
                            n_sig_last_ms[SIG_IDX_LIMITS] = r_in_now;
                        end
                    end
                    ID_SOC: begin
                        if (r_in_len >= MIN_LEN_SOC) begin
                            n_charge_state_raw         = r_in_payload[15:0];
                            n_sig_status[SIG_IDX_SOC]  = SIG_FRESH;
                            n_sig_last_ms[SIG_IDX_SOC] = r_in_now;
                        end
                    end
                    ID_ALARM: begin
                        if (r_in_len >= MIN_LEN_ALARM) begin
                            n_alarm_flag                 = |r_in_payload[15:0];
                            n_warning_flag               = |r_in_payload[31:16];
                            n_sig_status[SIG_IDX_ALARM]  = SIG_FRESH;
                            n_sig_last_ms[SIG_IDX_ALARM] = r_in_now;
                        end
                    end
                    ID_ENABLE: begin
                        if (r_in_len >= MIN_LEN_ENABLE) begin
                            n_charge_enable_flag          = r_in_payload[0];
                            n_sig_status[SIG_IDX_ENABLE]  = SIG_FRESH;
                            n_sig_last_ms[SIG_IDX_ENABLE] = r_in_now;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SIG; i++) begin
                r_sig_status[i] <= SIG_NEVER;
            end
        end else begin
            r_sig_status <= n_sig_status;
        end
    end

    // stored values are only read once their signal has been seen
    always_ff @(posedge i_clk) begin
        r_sig_last_ms        <= n_sig_last_ms;
        r_current_limit_da   <= n_current_limit_da;
        r_voltage_limit_dv   <= n_voltage_limit_dv;
        r_charge_state_raw   <= n_charge_state_raw;
        r_alarm_flag         <= n_alarm_flag;
        r_warning_flag       <= n_warning_flag;
        r_charge_enable_flag <= n_charge_enable_flag;
    end

    // ---------------------------------------------------------------
    // snapshot result
    // ---------------------------------------------------------------
    logic        w_lim_fresh;
    logic        w_soc_fresh;
    logic        w_alm_fresh;
    logic        w_en_fresh;
    logic        w_limit_ok;
    logic        w_alarm_force;
    logic [29:0] w_product_mw;
    logic        w_ceiling_active;
    logic [29:0] w_ceiling_mw;
    logic        w_soc_ok;
    logic [7:0]  w_soc_pct;
    logic        w_disc_pending;
    logic        w_link_lost;
    logic [OUT_DATA_W-1:0] w_result;

    assign w_lim_fresh = w_aged[SIG_IDX_LIMITS] == SIG_FRESH;
    assign w_soc_fresh = w_aged[SIG_IDX_SOC]    == SIG_FRESH;
    assign w_alm_fresh = w_aged[SIG_IDX_ALARM]  == SIG_FRESH;
    assign w_en_fresh  = w_aged[SIG_IDX_ENABLE] == SIG_FRESH;

    // both operands known non-negative here, so 15 x 15 bits suffice
    assign w_product_mw = 30'(r_current_limit_da[14:0]) * 30'(r_in_pcv[14:0]);
    assign w_limit_ok   = w_lim_fresh && !r_in_pcv[15] && (r_in_pcv != 16'sd0)
                          && !r_current_limit_da[15];

    // an active alarm, fresh or last seen before silence, forces zero power
    assign w_alarm_force = r_alarm_flag &&
                           (w_alm_fresh || (w_aged[SIG_IDX_ALARM] == SIG_STALE));

    assign w_ceiling_active = w_limit_ok || w_alarm_force;
    assign w_ceiling_mw     = (w_limit_ok && !w_alarm_force) ? w_product_mw : 30'd0;

    // out-of-range state of charge is not clamped, just untrusted
    assign w_soc_ok  = w_soc_fresh && (r_charge_state_raw <= SOC_MAX);
    assign w_soc_pct = w_soc_ok ? r_charge_state_raw[7:0] : 8'hFF;

    // pre-disconnect latches through silence on the last value seen
    assign w_disc_pending = !r_charge_enable_flag &&
                            (w_en_fresh || (w_aged[SIG_IDX_ENABLE] == SIG_STALE));

    assign w_link_lost = (w_aged[SIG_IDX_LIMITS] == SIG_STALE) ||
                         (w_aged[SIG_IDX_ENABLE] == SIG_STALE) ||
                         (w_aged[SIG_IDX_ALARM]  == SIG_STALE);

    assign w_result = {
        3'd0,
        w_link_lost,
        w_disc_pending,
        w_soc_pct,
        w_soc_ok,
        w_alm_fresh && r_warning_flag,
        w_alm_fresh && r_alarm_flag,
        w_lim_fresh ? r_voltage_limit_dv : 16'sd0,
        w_lim_fresh,
        w_ceiling_mw,
        w_ceiling_active
    };

    // ---------------------------------------------------------------
    // result register
    // ---------------------------------------------------------------
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_proc_go && w_is_snap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc_go && w_is_snap) begin
            r_out_data <= w_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule
